// ===== rtl/pwg_pkg.sv =====
// Shared package for the periodic waveform generator.
// Holds parameter defaults, register widths, waveform codes and register indexes.
// No dependencies.
package pwg_pkg;

    // parameter defaults
    localparam int TIME_WIDTH_DEF   = 32;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int PHASE_BITS_DEF   = 16;
    localparam int SINE_DEPTH_DEF   = 1024;

    // register and config port widths
    localparam int PERIOD_WIDTH    = 32;
    localparam int KIND_WIDTH      = 3;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    // waveform codes; any other code yields zero
    localparam logic [KIND_WIDTH-1:0] KIND_SINE     = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_SQUARE   = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_TRIANGLE = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_SAWTOOTH = 3'd3;

    // config register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KIND   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PERIOD = 2'd1;

    // reset values
    localparam logic [KIND_WIDTH-1:0]   KIND_RESET   = KIND_SINE;
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 32'd1000;

endpackage

// ===== rtl/pwg_rem_div.sv =====
// Pipelined restoring divider giving sample time modulo period.
// One quotient bit per stage, TIME_WIDTH stages. Depends on pwg_pkg.
module pwg_rem_div #(
    parameter int TIME_WIDTH = pwg_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [TIME_WIDTH-1:0]             i_time,
    input  logic [pwg_pkg::PERIOD_WIDTH-1:0]  i_period,
    output logic                              o_valid,
    output logic [pwg_pkg::PERIOD_WIDTH-1:0]  o_rem
);
    import pwg_pkg::*;

    logic                    r_vld  [TIME_WIDTH];
    logic [TIME_WIDTH-1:0]   r_time [TIME_WIDTH];
    logic [PERIOD_WIDTH-1:0] r_rem  [TIME_WIDTH];

    for (genvar s = 0; s < TIME_WIDTH; s++) begin : g_stage
        logic                    vld_in;
        logic [TIME_WIDTH-1:0]   time_in;
        logic [PERIOD_WIDTH-1:0] rem_in;
        logic [PERIOD_WIDTH:0]   wide;
        logic [PERIOD_WIDTH:0]   diff;
        logic                    ge;
        logic [PERIOD_WIDTH-1:0] n_rem;

        if (s == 0) begin : g_first
            assign vld_in  = i_valid;
            assign time_in = i_time;
            assign rem_in  = '0;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign time_in = r_time[s-1];
            assign rem_in  = r_rem[s-1];
        end

        // bring in next time bit, subtract period if it fits
        assign wide  = {rem_in, time_in[TIME_WIDTH-1]};
        assign diff  = wide - {1'b0, i_period};
        assign ge    = (wide >= {1'b0, i_period});
        assign n_rem = ge ? diff[PERIOD_WIDTH-1:0] : wide[PERIOD_WIDTH-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_time[s] <= time_in << 1;
            r_rem[s]  <= n_rem;
        end
    end

    assign o_valid = r_vld[TIME_WIDTH-1];
    assign o_rem   = r_rem[TIME_WIDTH-1];

endmodule

// ===== rtl/pwg_phase_div.sv =====
// Pipelined restoring divider forming phase = (rem << PHASE_BITS) / period.
// One phase bit per stage, PHASE_BITS stages. Depends on pwg_pkg.
module pwg_phase_div #(
    parameter int PHASE_BITS = pwg_pkg::PHASE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [pwg_pkg::PERIOD_WIDTH-1:0]  i_rem,
    input  logic [pwg_pkg::PERIOD_WIDTH-1:0]  i_period,
    output logic                              o_valid,
    output logic [PHASE_BITS-1:0]             o_phase
);
    import pwg_pkg::*;

    logic                    r_vld   [PHASE_BITS];
    logic [PERIOD_WIDTH-1:0] r_rem   [PHASE_BITS];
    logic [PHASE_BITS-1:0]   r_phase [PHASE_BITS];

    for (genvar j = 0; j < PHASE_BITS; j++) begin : g_stage
        logic                    vld_in;
        logic [PERIOD_WIDTH-1:0] rem_in;
        logic [PHASE_BITS-1:0]   phase_in;
        logic [PERIOD_WIDTH:0]   wide;
        logic [PERIOD_WIDTH:0]   diff;
        logic                    ge;
        logic [PERIOD_WIDTH-1:0] n_rem;

        if (j == 0) begin : g_first
            assign vld_in   = i_valid;
            assign rem_in   = i_rem;
            assign phase_in = '0;
        end else begin : g_next
            assign vld_in   = r_vld[j-1];
            assign rem_in   = r_rem[j-1];
            assign phase_in = r_phase[j-1];
        end

        // remainder stays below period, so doubled it fits one extra bit
        assign wide  = {rem_in, 1'b0};
        assign diff  = wide - {1'b0, i_period};
        assign ge    = (wide >= {1'b0, i_period});
        assign n_rem = ge ? diff[PERIOD_WIDTH-1:0] : wide[PERIOD_WIDTH-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]   <= n_rem;
            r_phase[j] <= {phase_in[PHASE_BITS-2:0], ge};
        end
    end

    assign o_valid = r_vld[PHASE_BITS-1];
    assign o_phase = r_phase[PHASE_BITS-1];

endmodule

// ===== rtl/pwg_sine_rom.sv =====
// Quarter-wave sine ROM with registered read, SINE_TABLE_DEPTH+1 entries.
// Contents built at elaboration by a fixed-point Taylor series. Depends on pwg_pkg.
module pwg_sine_rom #(
    parameter int SAMPLE_WIDTH     = pwg_pkg::SAMPLE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = pwg_pkg::SINE_DEPTH_DEF
) (
    input  logic                                     i_clk,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]    i_addr,
    output logic [SAMPLE_WIDTH-2:0]                  o_data
);
    import pwg_pkg::*;

    localparam int MAG_WIDTH = SAMPLE_WIDTH - 1;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [63:0] FULL_SCALE_64 = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;

    typedef logic [SINE_TABLE_DEPTH:0][MAG_WIDTH-1:0] t_rom;

    // sin(x) in Q30 to x^15, each term truncated, then scaled and rounded
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        rom = '0;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - term;
            v    = (sum * FULL_SCALE_64 + (64'd1 << 29)) >> 30;
            if (v > FULL_SCALE_64) begin
                v = FULL_SCALE_64;
            end
            rom[k] = v[MAG_WIDTH-1:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // registered read
    always_ff @(posedge i_clk) begin
        o_data <= SINE_ROM[i_addr];
    end

endmodule

// ===== rtl/pwg_shape.sv =====
// Waveform shaper: phase word to signed sample, three register stages.
// Index and linear segment, then ROM read and scaling, then final select.
// Depends on pwg_pkg and pwg_sine_rom.
module pwg_shape #(
    parameter int SAMPLE_WIDTH     = pwg_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_BITS       = pwg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = pwg_pkg::SINE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [PHASE_BITS-1:0]            i_phase,
    input  logic [pwg_pkg::KIND_WIDTH-1:0]   i_kind,
    output logic                             o_valid,
    output logic signed [SAMPLE_WIDTH-1:0]   o_sample_value
);
    import pwg_pkg::*;

    localparam int QUAD_BITS  = PHASE_BITS - 2;
    localparam int ADDR_WIDTH = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_WIDTH = QUAD_BITS + ADDR_WIDTH + 1;
    localparam int MAG_WIDTH  = SAMPLE_WIDTH - 1;
    localparam int U_WIDTH    = PHASE_BITS + 2;
    localparam int SC_WIDTH   = U_WIDTH + SAMPLE_WIDTH - 1;

    localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (QUAD_BITS - 1);
    localparam logic [PROD_WIDTH-1:0] DEPTH_PROD = PROD_WIDTH'(SINE_TABLE_DEPTH);
    localparam logic [ADDR_WIDTH:0]   DEPTH_CAP  = (ADDR_WIDTH + 1)'(SINE_TABLE_DEPTH);
    localparam logic [ADDR_WIDTH-1:0] DEPTH_IDX  = ADDR_WIDTH'(SINE_TABLE_DEPTH);
    localparam logic [U_WIDTH-1:0]    PH_ONE     = U_WIDTH'(1) << PHASE_BITS;
    localparam logic [U_WIDTH-1:0]    PH_THREE   = PH_ONE + (PH_ONE << 1);
    localparam logic [SAMPLE_WIDTH-1:0] FS_VAL   = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] MIN_VAL  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // ---- stage 1: sine index and linear-segment offset ----
    logic [1:0]            quad;
    logic [QUAD_BITS-1:0]  frac;
    logic [PROD_WIDTH-1:0] prod;
    logic [ADDR_WIDTH:0]   k_full;
    logic [ADDR_WIDTH-1:0] k_cap;
    logic [ADDR_WIDTH-1:0] n_k;
    logic [U_WIDTH-1:0]    p_ext;
    logic [U_WIDTH-1:0]    n_u;

    assign quad   = i_phase[PHASE_BITS-1:PHASE_BITS-2];
    assign frac   = i_phase[QUAD_BITS-1:0];
    assign prod   = PROD_WIDTH'(frac) * DEPTH_PROD + ROUND_HALF;
    assign k_full = prod[PROD_WIDTH-1:QUAD_BITS];
    assign k_cap  = (k_full > DEPTH_CAP) ? DEPTH_IDX : k_full[ADDR_WIDTH-1:0];
    assign n_k    = quad[0] ? (DEPTH_IDX - k_cap) : k_cap;
    assign p_ext  = U_WIDTH'(i_phase);

    // offset value u = v + 1 in units of 2^-PHASE_BITS, range 0 to 2
    always_comb begin
        n_u = '0;
        if (i_kind == KIND_TRIANGLE) begin
            priority if (quad == 2'd0) begin
                n_u = (p_ext << 2) + PH_ONE;
            end else if (quad == 2'd3) begin
                n_u = (p_ext << 2) - PH_THREE;
            end else begin
                n_u = PH_THREE - (p_ext << 2);
            end
        end else begin
            n_u = quad[1] ? ((p_ext << 1) - PH_ONE) : ((p_ext << 1) + PH_ONE);
        end
    end

    logic                  r1_vld;
    logic [ADDR_WIDTH-1:0] r1_k;
    logic                  r1_neg;
    logic                  r1_sq;
    logic [U_WIDTH-1:0]    r1_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_k   <= n_k;
        r1_neg <= quad[1];
        r1_sq  <= i_phase[PHASE_BITS-1];
        r1_u   <= n_u;
    end

    // ---- stage 2: table read, linear scale with saturation ----
    logic [MAG_WIDTH-1:0]    rom_data;
    logic [SC_WIDTH-1:0]     scaled_full;
    logic [SAMPLE_WIDTH:0]   scaled;
    logic [SAMPLE_WIDTH-1:0] n_lin;

    pwg_sine_rom #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r1_k),
        .o_data (rom_data)
    );

    assign scaled_full = SC_WIDTH'(r1_u) << (SAMPLE_WIDTH - 1);
    assign scaled      = scaled_full[SC_WIDTH-1:PHASE_BITS];
    // subtract half scale by flipping the sign bit; top of range caps at +FS
    assign n_lin = scaled[SAMPLE_WIDTH] ? FS_VAL
                 : {~scaled[SAMPLE_WIDTH-1], scaled[SAMPLE_WIDTH-2:0]};

    logic                    r2_vld;
    logic                    r2_neg;
    logic                    r2_sq;
    logic [SAMPLE_WIDTH-1:0] r2_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_neg <= r1_neg;
        r2_sq  <= r1_sq;
        r2_lin <= n_lin;
    end

    // ---- stage 3: pick the waveform ----
    logic [SAMPLE_WIDTH-1:0] sine_mag;
    logic [SAMPLE_WIDTH-1:0] n_out;

    assign sine_mag = {1'b0, rom_data};

    always_comb begin
        unique case (i_kind)
            KIND_SINE:     n_out = r2_neg ? (SAMPLE_WIDTH'(0) - sine_mag) : sine_mag;
            KIND_SQUARE:   n_out = r2_sq ? MIN_VAL : FS_VAL;
            KIND_TRIANGLE: n_out = r2_lin;
            KIND_SAWTOOTH: n_out = r2_lin;
            default:       n_out = '0;
        endcase
    end

    logic                    r3_vld;
    logic [SAMPLE_WIDTH-1:0] r3_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_out <= n_out;
    end

    assign o_valid        = r3_vld;
    assign o_sample_value = r3_out;

endmodule

// ===== rtl/periodic_waveform_generator_unit.sv =====
// Periodic waveform generator: sample time in, waveform sample out.
// Config registers, pipeline of remainder divider, phase divider and shaper.
// Depends on pwg_pkg, pwg_rem_div, pwg_phase_div, pwg_shape.
//
// Usage:
//   A sample time word is taken on every clock edge with i_start high and
//   o_busy low; o_busy is high only while reset is applied. One word can
//   enter every clock cycle.
//   Each result word appears on o_sample_value for one cycle with o_valid
//   high, after passing through the registered stages of the modulo
//   divider, the phase divider and the shaper (index, table read,
//   select). Results leave in input order; the receiver cannot stall.
//   Config words (i_cfg_index 0 = waveform kind, 1 = period) are written on
//   i_cfg_valid, always ready; write them only while no sample is in flight.
//   A period of zero is stored as one.
//   Reset drops all samples in flight and sets kind to sine, period to 1000.
module periodic_waveform_generator_unit #(
    parameter int TIME_WIDTH       = pwg_pkg::TIME_WIDTH_DEF,
    parameter int SAMPLE_WIDTH     = pwg_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_BITS       = pwg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = pwg_pkg::SINE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [TIME_WIDTH-1:0]                i_sample_time,
    output logic                                 o_valid,
    output logic signed [SAMPLE_WIDTH-1:0]       o_sample_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pwg_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [pwg_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);
    import pwg_pkg::*;

    localparam int LATENCY = TIME_WIDTH + PHASE_BITS + 3;
    localparam logic [SAMPLE_WIDTH-1:0] FS_VAL  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] MIN_VAL = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // ---- handshake ----
    logic r_busy;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy      = r_busy;
    assign accept      = i_start && !r_busy;
    assign o_cfg_ready = 1'b1;

    // ---- config registers ----
    logic [KIND_WIDTH-1:0]   r_kind;
    logic [PERIOD_WIDTH-1:0] r_period;
    logic [PERIOD_WIDTH-1:0] n_period;

    // zero period behaves as one
    assign n_period = (i_cfg_data[PERIOD_WIDTH-1:0] == '0) ? PERIOD_WIDTH'(1)
                    : i_cfg_data[PERIOD_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_RESET;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KIND:   r_kind   <= i_cfg_data[KIND_WIDTH-1:0];
                CFG_PERIOD: r_period <= n_period;
                default:    ;
            endcase
        end
    end

    // ---- datapath ----
    logic                    rem_vld;
    logic [PERIOD_WIDTH-1:0] rem;
    logic                    ph_vld;
    logic [PHASE_BITS-1:0]   phase;

    pwg_rem_div #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_rem_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_time   (i_sample_time),
        .i_period (r_period),
        .o_valid  (rem_vld),
        .o_rem    (rem)
    );

    pwg_phase_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rem_vld),
        .i_rem    (rem),
        .i_period (r_period),
        .o_valid  (ph_vld),
        .o_phase  (phase)
    );

    pwg_shape #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_shape (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (ph_vld),
        .i_phase        (phase),
        .i_kind         (r_kind),
        .o_valid        (o_valid),
        .o_sample_value (o_sample_value)
    );

    // ---- checks ----
    // every result traces back to an accepted start word
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result without matching start word");

    // modulo stage output always below the period
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_vld |-> (rem < r_period))
        else $error("remainder not below period");

    // square wave only takes the two rails
    a_square_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_kind == KIND_SQUARE)) |->
            ((o_sample_value == FS_VAL) || (o_sample_value == MIN_VAL)))
        else $error("square sample off the rails");

    // unknown waveform codes give zero
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_kind > KIND_SAWTOOTH)) |-> (o_sample_value == '0))
        else $error("unknown waveform gave nonzero sample");

endmodule

// ===== dv/tb_periodic_waveform_generator_unit.sv =====
// Self-checking testbench for periodic_waveform_generator_unit: directed and random samples.
// Carries its own waveform predictor and an in-order check of every result word.
// Depends on pwg_pkg and the periodic_waveform_generator_unit RTL.
module tb_periodic_waveform_generator_unit;
    import pwg_pkg::*;

    localparam int TIME_W     = TIME_WIDTH_DEF;
    localparam int SAMPLE_W   = SAMPLE_WIDTH_DEF;
    localparam int PHASE_W    = PHASE_BITS_DEF;
    localparam int SINE_DEPTH = SINE_DEPTH_DEF;
    localparam int LATENCY    = TIME_W + PHASE_W + 3;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 18;
    localparam int PHASE_ITEMS    = 95;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint PHASE_ONE  = longint'(1) << PHASE_W;
    localparam longint NEG_SCALE  = longint'(1) << (SAMPLE_W - 1);
    localparam longint FULL_SCALE = NEG_SCALE - 1;

    // codes with no waveform behind them, and register slots with no register
    localparam logic [KIND_WIDTH-1:0]      KIND_NONE_FIRST = 3'd4;
    localparam logic [KIND_WIDTH-1:0]      KIND_NONE_LAST  = 3'd7;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_A     = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_B     = 2'd3;

    typedef struct {
        logic [TIME_W-1:0]          t;
        logic signed [SAMPLE_W-1:0] value;
    } t_sample_word;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_start = 1'b0;
    logic [TIME_W-1:0]            i_sample_time = '0;
    logic                         i_cfg_valid = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]    i_cfg_data = '0;
    logic                         o_busy;
    logic                         o_valid;
    logic signed [SAMPLE_W-1:0]   o_sample_value;
    logic                         o_cfg_ready;

    // predictor copy of the registers
    logic [KIND_WIDTH-1:0]        model_kind;
    logic [PERIOD_WIDTH-1:0]      model_period;
    longint                       quarter_sine_lut [0:SINE_DEPTH];

    t_sample_word                 pending_samples [$];
    int                           error_count = 0;
    int                           stall_cycles = 0;

    periodic_waveform_generator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_sample_time  (i_sample_time),
        .o_valid        (o_valid),
        .o_sample_value (o_sample_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // quarter-wave sine, integer Taylor series in Q30
    task automatic fill_quarter_sine();
        longint unsigned x, x2, term, sum, v, n;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum * longint'(FULL_SCALE) + (64'd1 << 29)) >> 30;
            if (v > longint'(FULL_SCALE)) begin
                v = FULL_SCALE;
            end
            quarter_sine_lut[k] = longint'(v);
        end
    endtask

    // linear ramp value in phase units mapped onto the sample scale
    function automatic longint ramp_to_sample(longint v);
        longint r;
        r = (((v + PHASE_ONE) << (SAMPLE_W - 1)) >> PHASE_W) - NEG_SCALE;
        return (r > FULL_SCALE) ? FULL_SCALE : r;
    endfunction

    function automatic longint sine_at(longint ph);
        longint quad, f, k, mag;
        quad = (ph >> (PHASE_W - 2)) & 3;
        f    = ph & ((longint'(1) << (PHASE_W - 2)) - 1);
        k    = (f * SINE_DEPTH + (longint'(1) << (PHASE_W - 3))) >> (PHASE_W - 2);
        if (k > SINE_DEPTH) begin
            k = SINE_DEPTH;
        end
        if (quad[0]) begin
            k = SINE_DEPTH - k;
        end
        mag = quarter_sine_lut[k];
        return quad[1] ? -mag : mag;
    endfunction

    // expected sample value for one sample time under the current registers
    function automatic logic signed [SAMPLE_W-1:0] waveform_value(logic [TIME_W-1:0] t);
        longint unsigned per, rem;
        longint ph, val;
        per = (model_period == 0) ? 64'd1 : longint'(model_period);
        rem = longint'(t) % per;
        ph  = longint'((rem << PHASE_W) / per);
        case (model_kind)
            KIND_SINE: begin
                val = sine_at(ph);
            end
            KIND_SQUARE: begin
                val = (ph < PHASE_ONE / 2) ? FULL_SCALE : -NEG_SCALE;
            end
            KIND_TRIANGLE: begin
                if (ph < PHASE_ONE / 4) begin
                    val = ramp_to_sample(4 * ph);
                end else if (ph < 3 * (PHASE_ONE / 4)) begin
                    val = ramp_to_sample(2 * PHASE_ONE - 4 * ph);
                end else begin
                    val = ramp_to_sample(4 * ph - 4 * PHASE_ONE);
                end
            end
            KIND_SAWTOOTH: begin
                if (ph < PHASE_ONE / 2) begin
                    val = ramp_to_sample(2 * ph);
                end else begin
                    val = ramp_to_sample(2 * ph - 2 * PHASE_ONE);
                end
            end
            default: begin
                val = 0;
            end
        endcase
        return val[SAMPLE_W-1:0];
    endfunction

    // result checker and stall watchdog, sampled mid-cycle
    always @(negedge i_clk) begin
        t_sample_word want;
        if (i_rst_n && o_valid) begin
            stall_cycles = 0;
            if (pending_samples.size() == 0) begin
                $error("sample_value: expected none, actual %0d", o_sample_value);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                if (o_sample_value !== want.value) begin
                    $error("sample_value (time 0x%08h): expected %0d, actual %0d",
                           want.t, want.value, o_sample_value);
                    error_count++;
                end
            end
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // one sample time word; start stays high for a following word
    task automatic send_sample(logic [TIME_W-1:0] t);
        t_sample_word word;
        i_start       <= 1'b1;
        i_sample_time <= t;
        do @(posedge i_clk); while (o_busy);
        stall_cycles = 0;
        word.t     = t;
        word.value = waveform_value(t);
        pending_samples.push_back(word);
    endtask

    // stop sending, let every result come out and the pipeline empty
    task automatic drain_samples();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        stall_cycles = 0;
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KIND:   model_kind   = data[KIND_WIDTH-1:0];
            CFG_PERIOD: model_period = data;
            default:    ;
        endcase
        @(posedge i_clk);
    endtask

    // kind goes out with junk in the unused upper bits
    task automatic set_waveform(logic [KIND_WIDTH-1:0] kind, logic [PERIOD_WIDTH-1:0] period);
        logic [CFG_DATA_WIDTH-1:0] kind_word;
        drain_samples();
        kind_word = $urandom();
        kind_word[KIND_WIDTH-1:0] = kind;
        write_reg(CFG_KIND, kind_word);
        write_reg(CFG_PERIOD, period);
    endtask

    // sample times: full random, extremes, and spots around period and eighth-period edges
    function automatic logic [TIME_W-1:0] pick_time();
        longint unsigned per, t;
        per = (model_period == 0) ? 64'd1 : longint'(model_period);
        case ($urandom_range(0, 9))
            0: t = 0;
            1: t = {TIME_W{1'b1}};
            2, 3, 4: begin
                t = per * longint'($urandom()) + (per * $urandom_range(0, 7)) / 8
                    + $urandom_range(0, 2) - 1;
            end
            default: t = $urandom();
        endcase
        return t[TIME_W-1:0];
    endfunction

    task automatic test_reset_defaults();
        // sine at period 1000 straight out of reset
        send_sample(32'd0);
        send_sample(32'd250);
        send_sample(32'd500);
        send_sample(32'd750);
        send_sample(32'd999);
        send_sample(32'd1000);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_square_wide_period();
        set_waveform(KIND_SQUARE, 32'hFFFF_FFFF);
        send_sample(32'd0);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFE);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_zero_period();
        // zero period acts as one: phase is always 0
        set_waveform(KIND_SAWTOOTH, 32'd0);
        send_sample(32'hFFFF_FFFF);
        send_sample($urandom());
        set_waveform(KIND_TRIANGLE, 32'd1);
        send_sample(32'd0);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_short_ramps();
        set_waveform(KIND_TRIANGLE, 32'd4);
        send_sample(32'd1);
        send_sample(32'd2);
        send_sample(32'd3);
        set_waveform(KIND_SAWTOOTH, 32'd4);
        send_sample(32'd1);
        send_sample(32'd2);
        send_sample(32'd3);
    endtask

    task automatic test_unknown_kinds();
        set_waveform(KIND_NONE_FIRST, 32'd1000);
        send_sample(32'd250);
        set_waveform(KIND_NONE_LAST, 32'd1000);
        send_sample(32'd750);
    endtask

    task automatic test_spare_registers();
        // writes to unused slots must leave kind and period alone
        set_waveform(KIND_SINE, 32'd1000);
        write_reg(CFG_SPARE_A, $urandom());
        write_reg(CFG_SPARE_B, $urandom());
        send_sample(32'd250);
    endtask

    task automatic test_random();
        logic [KIND_WIDTH-1:0]   kind;
        logic [PERIOD_WIDTH-1:0] period;
        int sent, burst;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // first phases walk every kind code and the period extremes
            if (ph < 8) begin
                kind = KIND_WIDTH'(ph);
            end else if ($urandom_range(0, 1) != 0) begin
                kind = KIND_WIDTH'($urandom_range(0, 3));
            end else begin
                kind = KIND_WIDTH'($urandom_range(0, 7));
            end
            case (ph % 6)
                0: period = 32'd1;
                1: period = 32'hFFFF_FFFF;
                2: period = 32'd0;
                3: period = $urandom_range(2, 64);
                4: period = $urandom_range(65, 200000);
                default: period = ($urandom_range(0, 1) != 0) ? $urandom() :
                                  (32'd1 << $urandom_range(0, 31));
            endcase
            set_waveform(kind, period);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
                                                      $urandom_range(1, 40);
                for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
                    send_sample(pick_time());
                    sent++;
                end
                if ($urandom_range(0, 19) == 0) begin
                    drain_samples();
                end else begin
                    i_start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        fill_quarter_sine();
        model_kind   = KIND_RESET;
        model_period = PERIOD_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_square_wide_period();
        test_zero_period();
        test_short_ramps();
        test_unknown_kinds();
        test_spare_registers();
        test_random();
        drain_samples();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
